// File: hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Widths, types and the job word shared by the sliding min/max blocks.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned HALF_W      = 5;
   localparam int unsigned MAX_HALF    = 31;
   localparam int unsigned WIN_DEPTH   = 2 * MAX_HALF + 1;
   localparam int unsigned CNT_W       = $clog2(WIN_DEPTH + 1);
   localparam int unsigned ADDR_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int unsigned HALF_RESET  = 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [SAMPLE_BITS-1:0] usample_type;
   typedef logic        [HALF_W-1:0]      half_type;
   typedef logic        [CNT_W-1:0]       cnt_type;
   typedef logic        [ADDR_W-1:0]      addr_type;

   typedef struct packed {
      sample_type sample;
      cnt_type    used;
      cnt_type    nres;
      logic       frame_end;
      logic       short_frame;
   } job_type;

endpackage

// File: hw/rtl/smm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_req_if / smm_rsp_if / smm_csr_if
// Valid/ready channels for samples, results and the window register.
// ----------------------------------------------------------------------------
interface smm_req_if;
   logic                valid;
   logic                ready;
   smm_pkg::sample_type sample;
   logic                frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface smm_rsp_if;
   logic                 valid;
   logic                 ready;
   smm_pkg::sample_type  erosion;
   smm_pkg::sample_type  dilation;
   smm_pkg::sample_type  midpoint;
   smm_pkg::usample_type spread;
   logic                 last_out;
   logic                 short_frame;

   modport source (output valid, output erosion, output dilation, output midpoint,
                   output spread, output last_out, output short_frame, input ready);
   modport sink   (input valid, input erosion, input dilation, input midpoint,
                   input spread, input last_out, input short_frame, output ready);
endinterface

interface smm_csr_if;
   logic              valid;
   logic              ready;
   smm_pkg::half_type half_window;

   modport source (output valid, output half_window, input ready);
   modport sink   (input valid, input half_window, output ready);
endinterface

// File: hw/rtl/sliding_min_max_morphology.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_min_max_morphology
// Streaming 1D erosion/dilation with midpoint and spread over framed samples.
// ----------------------------------------------------------------------------
// req carries one signed sample word and a frame_end flag; rsp carries one
// result word (erosion, dilation, midpoint, spread, last_out, short_frame);
// csr writes half_window and is always ready; the user must write it only
// while the block is idle, which the block does not enforce. Results for
// position p come out once sample p+h has been taken. On frame_end the
// tail results repeat, last_out marking the final one. A sample that
// releases no result is only written to the window memory; any other stays
// in the back end until its result word is loaded, after a scan of the
// window length used = min(fill, 2h+1) when used is over 1: the window
// memory gives one entry a cycle. A two-word job queue lets the front keep
// taking samples while the back end scans, and the result register repeats
// its word while the back end scans the next sample.
// Reset clears the queue, the frame fill count and the output, and sets
// half_window to 1; the window memory needs no clearing. When rsp stalls
// the result word holds, the back end stops once its next result is ready,
// then the queue fills and req.ready drops.
// ----------------------------------------------------------------------------
module sliding_min_max_morphology (
   input  logic      clock,
   input  logic      reset,
   smm_req_if.sink   req,
   smm_rsp_if.source rsp,
   smm_csr_if.sink   csr
);

   logic             push_valid;
   logic             push_ready;
   smm_pkg::job_type push_job;
   logic             pop_valid;
   logic             pop_ready;
   smm_pkg::job_type pop_job;

   smm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   smm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   smm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp)
   );

endmodule

// File: hw/rtl/smm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_front
// Accepts sample words, tracks the frame fill and classifies each word into
// a job: window length to scan, number of results and frame flags.
// ----------------------------------------------------------------------------
module smm_front (
   input  logic              clock,
   input  logic              reset,
   smm_req_if.sink           req,
   smm_csr_if.sink           csr,
   output logic              push_valid,
   input  logic              push_ready,
   output smm_pkg::job_type  push_job
);

   smm_pkg::half_type half_ff;
   smm_pkg::half_type half_in;
   smm_pkg::cnt_type  fill_ff;
   smm_pkg::cnt_type  fill_in;
   smm_pkg::cnt_type  h_cl;
   smm_pkg::cnt_type  span;
   smm_pkg::cnt_type  c_new;
   logic              has_res;
   logic              accept;

   assign csr.ready  = 1'b1;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   always_comb begin
      if (int'(half_ff) > int'(smm_pkg::MAX_HALF)) begin
         h_cl = smm_pkg::cnt_type'(smm_pkg::MAX_HALF);
      end else begin
         h_cl = smm_pkg::cnt_type'(half_ff);
      end
      span  = smm_pkg::cnt_type'({h_cl, 1'b1});
      c_new = (fill_ff < smm_pkg::cnt_type'(smm_pkg::WIN_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
      has_res = c_new > h_cl;

      push_job.sample      = req.sample;
      push_job.used        = (c_new < span) ? c_new : span;
      push_job.frame_end   = req.frame_end;
      push_job.short_frame = req.frame_end && !has_res;
      if (req.frame_end) begin
         push_job.nres = has_res ? h_cl + smm_pkg::cnt_type'(1) : c_new;
      end else begin
         push_job.nres = has_res ? smm_pkg::cnt_type'(1) : smm_pkg::cnt_type'(0);
      end

      half_in = (csr.valid) ? csr.half_window : half_ff;
      fill_in = fill_ff;
      if (accept) begin
         fill_in = req.frame_end ? smm_pkg::cnt_type'(0) : c_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= smm_pkg::half_type'(smm_pkg::HALF_RESET);
         fill_ff <= '0;
      end else begin
         half_ff <= half_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// File: hw/rtl/smm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_queue
// Two-entry job queue between the classifying front and the scanning back.
// ----------------------------------------------------------------------------
module smm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  smm_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output smm_pkg::job_type pop_job
);

   smm_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/smm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_back
// Stores each sample in the window memory, scans the window one entry a
// cycle for min and max, and repeats the result word as the job requires.
// ----------------------------------------------------------------------------
module smm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  smm_pkg::job_type pop_job,
   smm_rsp_if.source        rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int unsigned MEM_DEPTH = 2 ** smm_pkg::ADDR_W;
   localparam int unsigned MSB       = smm_pkg::SAMPLE_BITS - 1;

   smm_pkg::sample_type  mem_ff [MEM_DEPTH];
   smm_pkg::sample_type  rdata_ff;
   smm_pkg::addr_type    raddr;

   logic [1:0]           state_ff;
   logic [1:0]           state_in;
   smm_pkg::addr_type    wptr_ff;
   smm_pkg::addr_type    wptr_in;
   smm_pkg::addr_type    base_ff;
   smm_pkg::addr_type    base_in;
   smm_pkg::cnt_type     k_ff;
   smm_pkg::cnt_type     k_in;
   smm_pkg::cnt_type     used_ff;
   smm_pkg::cnt_type     used_in;
   smm_pkg::cnt_type     nres_ff;
   smm_pkg::cnt_type     nres_in;
   logic                 end_ff;
   logic                 end_in;
   logic                 short_ff;
   logic                 short_in;
   logic                 rd_pend_ff;
   logic                 rd_pend_in;
   smm_pkg::sample_type  lo_ff;
   smm_pkg::sample_type  lo_in;
   smm_pkg::sample_type  hi_ff;
   smm_pkg::sample_type  hi_in;

   smm_pkg::sample_type  out_lo_ff;
   smm_pkg::sample_type  out_lo_in;
   smm_pkg::sample_type  out_hi_ff;
   smm_pkg::sample_type  out_hi_in;
   smm_pkg::sample_type  out_mid_ff;
   smm_pkg::sample_type  out_mid_in;
   smm_pkg::usample_type out_spread_ff;
   smm_pkg::usample_type out_spread_in;
   smm_pkg::cnt_type     out_left_ff;
   smm_pkg::cnt_type     out_left_in;
   logic                 out_end_ff;
   logic                 out_end_in;
   logic                 out_short_ff;
   logic                 out_short_in;

   logic [smm_pkg::SAMPLE_BITS:0] sum;
   logic [smm_pkg::SAMPLE_BITS:0] sum_adj;
   logic                 do_pop;
   logic                 out_fire;
   logic                 out_free;
   logic                 load_out;

   assign pop_ready = state_ff == ST_IDLE;
   assign do_pop    = pop_valid && pop_ready;
   assign raddr     = base_ff - smm_pkg::addr_type'(k_ff);

   assign rsp.valid       = out_left_ff != '0;
   assign rsp.erosion     = out_lo_ff;
   assign rsp.dilation    = out_hi_ff;
   assign rsp.midpoint    = out_mid_ff;
   assign rsp.spread      = out_spread_ff;
   assign rsp.last_out    = out_end_ff && (out_left_ff == smm_pkg::cnt_type'(1));
   assign rsp.short_frame = out_short_ff;

   assign out_fire = rsp.valid && rsp.ready;
   assign out_free = (out_left_ff == '0) || ((out_left_ff == smm_pkg::cnt_type'(1)) && rsp.ready);
   assign load_out = (state_ff == ST_DONE) && !rd_pend_ff && out_free;

   always_comb begin
      sum     = {lo_ff[MSB], lo_ff} + {hi_ff[MSB], hi_ff};
      sum_adj = (sum[smm_pkg::SAMPLE_BITS] && sum[0]) ? sum + 1'b1 : sum;
   end

   always_comb begin
      state_in   = state_ff;
      wptr_in    = wptr_ff;
      base_in    = base_ff;
      k_in       = k_ff;
      used_in    = used_ff;
      nres_in    = nres_ff;
      end_in     = end_ff;
      short_in   = short_ff;
      rd_pend_in = 1'b0;
      lo_in      = lo_ff;
      hi_in      = hi_ff;

      if (rd_pend_ff) begin
         if (rdata_ff < lo_ff) begin
            lo_in = rdata_ff;
         end
         if (rdata_ff > hi_ff) begin
            hi_in = rdata_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (do_pop) begin
               wptr_in  = wptr_ff + 1'b1;
               base_in  = wptr_ff;
               k_in     = smm_pkg::cnt_type'(1);
               used_in  = pop_job.used;
               nres_in  = pop_job.nres;
               end_in   = pop_job.frame_end;
               short_in = pop_job.short_frame;
               lo_in    = pop_job.sample;
               hi_in    = pop_job.sample;
               if (pop_job.nres == '0) begin
                  state_in = ST_IDLE;
               end else if (pop_job.used > smm_pkg::cnt_type'(1)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            k_in       = k_ff + 1'b1;
            if (k_ff == used_ff - smm_pkg::cnt_type'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_lo_in     = out_lo_ff;
      out_hi_in     = out_hi_ff;
      out_mid_in    = out_mid_ff;
      out_spread_in = out_spread_ff;
      out_end_in    = out_end_ff;
      out_short_in  = out_short_ff;
      out_left_in   = out_fire ? out_left_ff - smm_pkg::cnt_type'(1) : out_left_ff;
      if (load_out) begin
         out_lo_in     = lo_ff;
         out_hi_in     = hi_ff;
         out_mid_in    = smm_pkg::sample_type'(sum_adj[smm_pkg::SAMPLE_BITS:1]);
         out_spread_in = smm_pkg::usample_type'(hi_ff - lo_ff);
         out_end_in    = end_ff;
         out_short_in  = short_ff;
         out_left_in   = nres_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         mem_ff[wptr_ff] <= pop_job.sample;
      end
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      k_ff          <= k_in;
      used_ff       <= used_in;
      nres_ff       <= nres_in;
      end_ff        <= end_in;
      short_ff      <= short_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      out_lo_ff     <= out_lo_in;
      out_hi_ff     <= out_hi_in;
      out_mid_ff    <= out_mid_in;
      out_spread_ff <= out_spread_in;
      out_end_ff    <= out_end_in;
      out_short_ff  <= out_short_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wptr_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         out_left_ff <= '0;
      end else begin
         state_ff    <= state_in;
         wptr_ff     <= wptr_in;
         rd_pend_ff  <= rd_pend_in;
         out_left_ff <= out_left_in;
      end
   end

endmodule
